@@ src/assert_macros.svh @@
// Assertion macros shared by the timer queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

@@ src/dltq_pkg.sv @@
`timescale 1ns / 1ps
package dltq_pkg;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CLEAR_CHK = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SET = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_EXPIRE = 2'd2
  } kind_t;

  localparam logic [1:0] REG_TICK = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;
  localparam logic [1:0] REG_MAXID = 2'd3;
  localparam int MaxResults = 16;

  typedef struct packed {
    logic [1:0] command;
    logic [31:0] owner_id;
    logic [15:0] timer_type;
    logic [31:0] duration;
    logic [15:0] timer_id;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] result_id;
    logic [31:0] event_owner;
    logic [15:0] event_type;
    logic status;
    logic found;
    logic last;
  } out_req_t;

  typedef struct packed {
    logic load;
    logic walk_init;
    logic set_step;
    logic set_commit;
    logic clr_step;
    logic clr_commit;
    logic tick_sub;
    logic exp_pop;
    logic emit_set;
    logic emit_clear;
    logic emit_exp;
    logic emit_last;
    logic clear_bad;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic id_zero;
    logic set_ok;
    logic walk_done;
    logic clr_hit;
    logic clr_end;
    logic exp_ready;
    logic exp_last;
  } sts_t;

endpackage

@@ src/dltq_ctrl.sv @@
`timescale 1ns / 1ps
module dltq_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  dltq_pkg::sts_t sts,
  output dltq_pkg::ctl_t ctl
);
  import dltq_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC = 8'b00000010,
    S_SWALK = 8'b00000100,
    S_SCOM = 8'b00001000,
    S_CWALK = 8'b00010000,
    S_CCOM = 8'b00100000,
    S_TSUB = 8'b01000000,
    S_EXP = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ctl.walk_init = 1'b1;
        case (sts.cmd)
          CMD_SET: begin
            if (sts.set_ok) begin
              state_nxt = S_SWALK;
            end else begin
              ctl.emit_set = 1'b1;
              ctl.emit_last = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_CLEAR, CMD_CLEAR_CHK: begin
            if (sts.id_zero) begin
              ctl.emit_clear = 1'b1;
              ctl.clear_bad = 1'b1;
              ctl.emit_last = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_CWALK;
            end
          end
          default: begin
            state_nxt = S_TSUB;
          end
        endcase
      end
      S_SWALK: begin
        if (sts.walk_done) begin
          state_nxt = S_SCOM;
        end else begin
          ctl.set_step = 1'b1;
        end
      end
      S_SCOM: begin
        ctl.set_commit = 1'b1;
        ctl.emit_set = 1'b1;
        ctl.emit_last = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CWALK: begin
        if (sts.clr_hit || sts.clr_end) begin
          state_nxt = S_CCOM;
        end else begin
          ctl.clr_step = 1'b1;
        end
      end
      S_CCOM: begin
        ctl.clr_commit = 1'b1;
        ctl.emit_clear = 1'b1;
        ctl.emit_last = 1'b1;
        state_nxt = S_IDLE;
      end
      S_TSUB: begin
        ctl.tick_sub = 1'b1;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        if (sts.exp_ready) begin
          ctl.exp_pop = 1'b1;
          ctl.emit_exp = 1'b1;
          ctl.emit_last = sts.exp_last;
          if (sts.exp_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_load_dec, clk, rst_n, ctl.load, state_r == S_DEC, "load not followed by decode")
  `ASSERT_IMPL(a_emit_one, clk, rst_n, ctl.emit_set || ctl.emit_clear || ctl.emit_exp,
               $onehot({ctl.emit_set, ctl.emit_clear, ctl.emit_exp}), "two results at once")
  `ASSERT_NEXT(a_last_idle, clk, rst_n, ctl.emit_last, !busy, "last result not ending request")
endmodule

@@ src/dltq_dp.sv @@
`timescale 1ns / 1ps
module dltq_dp #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  dltq_pkg::in_req_t in_req,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  dltq_pkg::ctl_t ctl,
  output dltq_pkg::sts_t sts,
  output logic out_valid,
  output dltq_pkg::out_req_t out_req
);
  import dltq_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int RW = $clog2(MaxResults + 1);

  logic [15:0] tick_r, min_r, margin_r, maxid_r;
  logic [TIMER_SLOTS-1:0] valid_r;
  logic [15:0] eid_r [TIMER_SLOTS];
  logic [31:0] eown_r [TIMER_SLOTS];
  logic [15:0] etyp_r [TIMER_SLOTS];
  logic [31:0] edel_r [TIMER_SLOTS];
  logic [IW-1:0] enext_r [TIMER_SLOTS];
  logic [IW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [15:0] idc_r;
  in_req_t req_r;
  logic [IW-1:0] cur_r, prev_r, slot_r;
  logic have_prev_r;
  logic [CW-1:0] i_r;
  logic [31:0] d_r;
  logic [RW-1:0] n_r;
  logic out_valid_r;
  out_req_t out_r;
  out_req_t out_nxt;

  logic [IW-1:0] free_slot;
  logic [16:0] id_inc;
  logic [15:0] step;
  logic [16:0] limit;
  logic [31:0] cur_del;
  logic walk_more;

  always_comb begin
    free_slot = '0;
    for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_slot = IW'(k);
      end
    end
  end

  assign cur_del = edel_r[cur_r];
  assign walk_more = (i_r < count_r);
  assign id_inc = {1'b0, idc_r} + 17'd1;
  assign step = (tick_r > min_r) ? tick_r : min_r;
  assign limit = {margin_r, 1'b0};

  assign sts.cmd = cmd_t'(req_r.command);
  assign sts.id_zero = (req_r.timer_id == 16'd0);
  assign sts.set_ok = (req_r.duration >= {16'd0, min_r}) && (count_r < CW'(TIMER_SLOTS));
  assign sts.walk_done = !walk_more || (d_r < cur_del);
  assign sts.clr_hit = walk_more && (eid_r[cur_r] == req_r.timer_id);
  assign sts.clr_end = !walk_more;
  assign sts.exp_ready = (count_r != '0) && (n_r < RW'(MaxResults))
                         && ({15'd0, edel_r[head_r][31:0]} < {30'd0, limit});
  assign sts.exp_last = (count_r == CW'(1)) || (n_r == RW'(MaxResults - 1))
                        || ({15'd0, edel_r[enext_r[head_r]]} >= {30'd0, limit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= 16'd10;
      min_r <= 16'd10;
      margin_r <= 16'd5;
      maxid_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK: tick_r <= cfg_data;
        REG_MIN: min_r <= cfg_data;
        REG_MARGIN: margin_r <= cfg_data;
        REG_MAXID: maxid_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      head_r <= '0;
      count_r <= '0;
      idc_r <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit_set || ctl.emit_clear || ctl.emit_exp;
      if (ctl.set_commit) begin
        valid_r[slot_r] <= 1'b1;
        eid_r[slot_r] <= idc_r;
        eown_r[slot_r] <= req_r.owner_id;
        etyp_r[slot_r] <= req_r.timer_type;
        edel_r[slot_r] <= d_r;
        if (have_prev_r) begin
          enext_r[slot_r] <= walk_more ? cur_r : '0;
          enext_r[prev_r] <= slot_r;
        end else begin
          enext_r[slot_r] <= head_r;
          head_r <= slot_r;
        end
        if (walk_more) begin
          edel_r[cur_r] <= cur_del - d_r;
        end
        count_r <= count_r + CW'(1);
        idc_r <= (id_inc > {1'b0, maxid_r}) ? 16'd1 : id_inc[15:0];
      end
      if (ctl.clr_commit && walk_more &&
          (req_r.command != CMD_CLEAR_CHK || etyp_r[cur_r] == req_r.timer_type)) begin
        if (i_r + CW'(1) < count_r) begin
          edel_r[enext_r[cur_r]] <= edel_r[enext_r[cur_r]] + cur_del;
        end
        if (have_prev_r) begin
          enext_r[prev_r] <= enext_r[cur_r];
        end else begin
          head_r <= enext_r[cur_r];
        end
        valid_r[cur_r] <= 1'b0;
        count_r <= count_r - CW'(1);
      end
      if (ctl.tick_sub && count_r != '0) begin
        edel_r[head_r] <= (edel_r[head_r] > {16'd0, step}) ? edel_r[head_r] - {16'd0, step}
                                                         : 32'd0;
      end
      if (ctl.exp_pop) begin
        valid_r[head_r] <= 1'b0;
        head_r <= (count_r == CW'(1)) ? '0 : enext_r[head_r];
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.last = ctl.emit_last;
    if (ctl.emit_set) begin
      out_nxt.kind = KIND_SET;
      out_nxt.result_id = ctl.set_commit ? idc_r : 16'd0;
    end
    if (ctl.emit_clear) begin
      out_nxt.kind = KIND_CLEAR;
      out_nxt.status = ctl.clear_bad;
      out_nxt.result_id = ctl.clear_bad ? 16'd0 : req_r.timer_id;
      out_nxt.found = !ctl.clear_bad && walk_more &&
          (req_r.command != CMD_CLEAR_CHK || etyp_r[cur_r] == req_r.timer_type);
    end
    if (ctl.emit_exp) begin
      out_nxt.kind = KIND_EXPIRE;
      out_nxt.result_id = eid_r[head_r];
      out_nxt.event_owner = eown_r[head_r];
      out_nxt.event_type = etyp_r[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_req;
    end
    if (ctl.walk_init) begin
      cur_r <= head_r;
      prev_r <= '0;
      have_prev_r <= 1'b0;
      i_r <= '0;
      d_r <= req_r.duration;
      slot_r <= free_slot;
      n_r <= '0;
    end
    if (ctl.set_step) begin
      d_r <= d_r - cur_del;
      prev_r <= cur_r;
      have_prev_r <= 1'b1;
      cur_r <= enext_r[cur_r];
      i_r <= i_r + CW'(1);
    end
    if (ctl.clr_step) begin
      prev_r <= cur_r;
      have_prev_r <= 1'b1;
      cur_r <= enext_r[cur_r];
      i_r <= i_r + CW'(1);
    end
    if (ctl.exp_pop) begin
      n_r <= n_r + RW'(1);
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req = out_r;

  `ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(TIMER_SLOTS), "count overflow")
  `ASSERT_IMPL(a_count_valid, clk, rst_n, 1'b1, $countones(valid_r) == int'(count_r),
               "count differs from valid slots")
  `ASSERT_NEXT(a_set_grow, clk, rst_n, ctl.set_commit, count_r == $past(count_r) + CW'(1),
               "set did not grow list")
endmodule

@@ src/delta_list_timer_queue.sv @@
`timescale 1ns / 1ps
// Channel   Ports                          Direction
// input     start, busy, in_req            in, busy out
// result    out_valid, out_req             out
// config    cfg_we, cfg_index, cfg_data    in
// Set and clear walk up to TIMER_SLOTS entries of the list, one step a cycle.
// A rejected set or a clear of id zero is answered from decode, with no walk.
// Tick lowers the head delta by the step, then pops expired timers, at most 16 expiries.
// Reset is synchronous, active low, and empties the list.
// Results leave on out_valid for one cycle each; the receiver cannot stall.
module delta_list_timer_queue #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  dltq_pkg::in_req_t in_req,
  output logic out_valid,
  output dltq_pkg::out_req_t out_req,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import dltq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  dltq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  dltq_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .ctl(ctl), .sts(sts),
    .out_valid(out_valid), .out_req(out_req)
  );
endmodule
